// ===== rtl/core/multi_list_stack_queue_engine_defines.svh =====
// assertion macros for the list engine
`ifndef MULTI_LIST_STACK_QUEUE_ENGINE_DEFINES_SVH
`define MULTI_LIST_STACK_QUEUE_ENGINE_DEFINES_SVH

// condition holds in the same cycle
`define MLSQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define MLSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mlsq_pkg.sv =====
package mlsq_pkg;

    localparam logic [1:0] MODE_CREATE_STACK = 2'd0;
    localparam logic [1:0] MODE_CREATE_QUEUE = 2'd1;
    localparam logic [1:0] MODE_PUSH         = 2'd2;
    localparam logic [1:0] MODE_POP          = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EXISTS = 3'd1;
    localparam logic [2:0] ST_NOLIST = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIST,
        S_LINK,
        S_POP
    } state_t;

    typedef struct packed {
        logic link_rd;
        logic link_wr;
        logic value_rd;
        logic value_wr;
    } pool_ctl_t;

endpackage

// ===== rtl/core/mlsq_pool.sv =====
module mlsq_pool
    import mlsq_pkg::*;
#(
    parameter int POOL_DEPTH  = 256,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                             clk,
    input  pool_ctl_t                        ctl,
    input  logic [$clog2(POOL_DEPTH)-1:0]    link_raddr,
    input  logic [$clog2(POOL_DEPTH)-1:0]    link_waddr,
    input  logic [$clog2(POOL_DEPTH)-1:0]    link_wdata,
    output logic [$clog2(POOL_DEPTH)-1:0]    link_rdata,
    input  logic [$clog2(POOL_DEPTH)-1:0]    value_raddr,
    input  logic [$clog2(POOL_DEPTH)-1:0]    value_waddr,
    input  logic [VALUE_WIDTH-1:0]           value_wdata,
    output logic [VALUE_WIDTH-1:0]           value_rdata
);

    localparam int PW = $clog2(POOL_DEPTH);

    logic [PW-1:0]          link_mem  [POOL_DEPTH];
    logic [VALUE_WIDTH-1:0] value_mem [POOL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.link_wr)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (ctl.link_rd)
        begin
            link_rdata <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.value_wr)
        begin
            value_mem[value_waddr] <= value_wdata;
        end
        if (ctl.value_rd)
        begin
            value_rdata <= value_mem[value_raddr];
        end
    end

endmodule

// ===== rtl/core/multi_list_stack_queue_engine.sv =====
// channel  | beat moved                     | handshake
// ---------+--------------------------------+---------------------
// input    | mode, list_id, push_value      | in_valid / in_stall
// output   | status, popped_value           | out_valid / out_stall
//
// every beat first reads the list table; create, push and errors then answer, a queue
// push to a non-empty list then writes the tail link, and a pop reads the pool.
// one beat in flight at a time.
// rst_n is asynchronous and clears list valid bits, pool counters and control.
// a stalled result stays in the output register; a new beat is taken once
// that register is free or being taken in the same cycle.
`include "multi_list_stack_queue_engine_defines.svh"

module multi_list_stack_queue_engine
    import mlsq_pkg::*;
#(
    parameter int NUM_LISTS   = 8,
    parameter int POOL_DEPTH  = 256,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [2:0]         list_id,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [31:0] popped_value
);

    localparam int LIST_AW = $clog2(NUM_LISTS);
    localparam int PW      = $clog2(POOL_DEPTH);
    localparam int CW      = $clog2(POOL_DEPTH + 1);
    localparam int EW      = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

    typedef struct packed {
        logic          is_queue;
        logic [CW-1:0] count;
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
    } list_entry_t;

    list_entry_t list_mem [NUM_LISTS];
    list_entry_t list_rdata;
    list_entry_t list_wdata;
    logic        list_rd;
    logic        list_wr;

    state_t                 state_reg, state_next;
    logic [1:0]             mode_reg;
    logic [2:0]             id_reg;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [PW-1:0]          slot_reg, slot_next;
    logic [NUM_LISTS-1:0]   used_reg, used_next;
    logic [CW-1:0]          fresh_reg, fresh_next;
    logic [PW-1:0]          free_top_reg, free_top_next;
    logic [CW-1:0]          free_count_reg, free_count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             status_reg, status_next;
    logic signed [31:0]     popped_reg, popped_next;

    pool_ctl_t              pool_ctl;
    logic [PW-1:0]          link_raddr, link_waddr, link_wdata, link_rdata;
    logic [PW-1:0]          value_raddr, value_waddr;
    logic [VALUE_WIDTH-1:0] value_rdata;

    logic                   accept;
    logic [LIST_AW+2:0]     in_id_wide, reg_id_wide;
    logic [LIST_AW-1:0]     in_idx, reg_idx;
    logic                   in_range, used, is_create, is_push, is_pop;
    logic                   have_free, have_fresh, can_alloc, was_empty;
    logic [PW-1:0]          slot;
    logic                   go_pop, go_link;
    logic [2:0]             list_status;
    logic [EW-1:0]          push_ext;
    logic signed [VALUE_WIDTH-1:0] pop_raw;
    logic signed [EW-1:0]   pop_ext;

    assign accept      = in_valid && !in_stall;
    assign in_id_wide  = {{LIST_AW{1'b0}}, list_id};
    assign reg_id_wide = {{LIST_AW{1'b0}}, id_reg};
    assign in_idx      = in_id_wide[LIST_AW-1:0];
    assign reg_idx     = reg_id_wide[LIST_AW-1:0];

    assign in_range   = {29'd0, id_reg} < 32'(NUM_LISTS);
    assign used       = in_range && used_reg[reg_idx];
    assign is_create  = (mode_reg == MODE_CREATE_STACK) || (mode_reg == MODE_CREATE_QUEUE);
    assign is_push    = (mode_reg == MODE_PUSH);
    assign is_pop     = (mode_reg == MODE_POP);
    assign have_free  = (free_count_reg != '0);
    assign have_fresh = (fresh_reg != CW'(POOL_DEPTH));
    assign can_alloc  = have_free || have_fresh;
    assign was_empty  = (list_rdata.count == '0);
    assign slot       = have_free ? free_top_reg : fresh_reg[PW-1:0];
    assign go_pop     = is_pop && used && !was_empty;
    assign go_link    = is_push && used && can_alloc && list_rdata.is_queue && !was_empty;

    assign push_ext = EW'(unsigned'(push_value));
    assign pop_raw  = signed'(value_rdata);
    assign pop_ext  = EW'(pop_raw);

    always_comb
    begin
        priority if (!in_range)
        begin
            list_status = ST_NOLIST;
        end
        else if (is_create)
        begin
            list_status = used ? ST_EXISTS : ST_OK;
        end
        else if (!used)
        begin
            list_status = ST_NOLIST;
        end
        else if (is_push)
        begin
            list_status = can_alloc ? ST_OK : ST_FULL;
        end
        else
        begin
            list_status = was_empty ? ST_EMPTY : ST_OK;
        end
    end

    // next state
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_LIST : S_IDLE;
            S_LIST:  state_next = go_pop ? S_POP : (go_link ? S_LINK : S_IDLE);
            S_LINK:  state_next = S_IDLE;
            S_POP:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_stall        = !((state_reg == S_IDLE) && (!out_valid_reg || !out_stall));
        list_rd         = 1'b0;
        list_wr         = 1'b0;
        list_wdata      = list_rdata;
        pool_ctl        = '0;
        link_raddr      = free_top_reg;
        link_waddr      = slot;
        link_wdata      = '0;
        value_raddr     = list_rdata.head;
        value_waddr     = slot;
        val_next        = val_reg;
        slot_next       = slot_reg;
        used_next       = used_reg;
        fresh_next      = fresh_reg;
        free_top_next   = free_top_reg;
        free_count_next = free_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        popped_next     = popped_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                list_rd          = accept;
                pool_ctl.link_rd = accept;
                if (accept)
                begin
                    val_next = push_ext[VALUE_WIDTH-1:0];
                end
            end
            S_LIST:
            begin
                if (!go_pop && !go_link)
                begin
                    out_valid_next = 1'b1;
                    status_next    = list_status;
                    popped_next    = '0;
                end
                if (is_create && in_range && !used)
                begin
                    list_wr             = 1'b1;
                    list_wdata.is_queue = (mode_reg == MODE_CREATE_QUEUE);
                    list_wdata.count    = '0;
                    used_next[reg_idx]  = 1'b1;
                end
                if (is_push && used && can_alloc)
                begin
                    if (have_free)
                    begin
                        free_top_next   = link_rdata;
                        free_count_next = free_count_reg - CW'(1);
                    end
                    else
                    begin
                        fresh_next = fresh_reg + CW'(1);
                    end
                    pool_ctl.value_wr = 1'b1;
                    pool_ctl.link_wr  = 1'b1;
                    link_wdata        = list_rdata.is_queue ? '0 : list_rdata.head;
                    list_wr           = 1'b1;
                    list_wdata.count  = list_rdata.count + CW'(1);
                    if (list_rdata.is_queue)
                    begin
                        list_wdata.tail = slot;
                        list_wdata.head = was_empty ? slot : list_rdata.head;
                    end
                    else
                    begin
                        list_wdata.head = slot;
                        list_wdata.tail = was_empty ? slot : list_rdata.tail;
                    end
                    slot_next = slot;
                end
                if (go_pop)
                begin
                    pool_ctl.value_rd = 1'b1;
                    pool_ctl.link_rd  = 1'b1;
                    link_raddr        = list_rdata.head;
                end
            end
            S_LINK:
            begin
                pool_ctl.link_wr = 1'b1;
                link_waddr       = list_rdata.tail;
                link_wdata       = slot_reg;
                out_valid_next   = 1'b1;
                status_next      = ST_OK;
                popped_next      = '0;
            end
            S_POP:
            begin
                list_wr          = 1'b1;
                list_wdata.head  = link_rdata;
                list_wdata.count = list_rdata.count - CW'(1);
                pool_ctl.link_wr = 1'b1;
                link_waddr       = list_rdata.head;
                link_wdata       = free_top_reg;
                free_top_next    = list_rdata.head;
                free_count_next  = free_count_reg + CW'(1);
                out_valid_next   = 1'b1;
                status_next      = ST_OK;
                popped_next      = pop_ext[31:0];
            end
            default:
            begin
                list_rd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (list_wr)
        begin
            list_mem[reg_idx] <= list_wdata;
        end
        if (list_rd)
        begin
            list_rdata <= list_mem[in_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            fresh_reg      <= '0;
            free_top_reg   <= '0;
            free_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            fresh_reg      <= fresh_next;
            free_top_reg   <= free_top_next;
            free_count_reg <= free_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            id_reg   <= list_id;
        end
        val_reg    <= val_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    mlsq_pool #(
        .POOL_DEPTH  (POOL_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_pool (
        .clk         (clk),
        .ctl         (pool_ctl),
        .link_raddr  (link_raddr),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .link_rdata  (link_rdata),
        .value_raddr (value_raddr),
        .value_waddr (value_waddr),
        .value_wdata (val_reg),
        .value_rdata (value_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;

    // free entries were all handed out once
    `MLSQ_ASSERT_SAME(a_free_le_fresh, 1'b1,
        (free_count_reg <= fresh_reg) && (fresh_reg <= CW'(POOL_DEPTH)),
        "free count exceeds entries handed out")
    // an accepted beat always starts work
    `MLSQ_ASSERT_NEXT(a_accept_busy, accept, state_reg == S_LIST,
        "accepted beat did not reach list lookup")
    // a result only appears from a work state
    `MLSQ_ASSERT_SAME(a_result_source, $rose(out_valid_reg), $past(state_reg != S_IDLE),
        "result raised outside a work state")
    // failed or non-pop beats return zero
    `MLSQ_ASSERT_SAME(a_error_zero, out_valid_reg && (status_reg != ST_OK), popped_reg == '0,
        "nonzero value on error result")

endmodule
